// ===== sv/magnetometer_calibrate_and_heading_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the magnetometer calibrate and heading unit
// Implication and next-cycle checks, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_CALIBRATE_AND_HEADING_UNIT_DEFINES_SVH
`define MAGNETOMETER_CALIBRATE_AND_HEADING_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MCHU_A_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MCHU_A_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MCHU_A_IMPL(lbl, ante, cons, msg)
`define MCHU_A_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/mchu_pkg.sv =====
// ----------------------------------------------------------------------------
// mchu_pkg
// Shared types, codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mchu_pkg;

  localparam int unsigned SW       = 16;  // sample width
  localparam int unsigned CSW      = 18;  // calibration group sum
  localparam int unsigned HSW      = 26;  // heading sum
  localparam int unsigned SPW      = 17;  // span sum width
  localparam int unsigned AXW      = 27;  // heading axis value
  localparam int unsigned RW       = 16;  // span ratio width
  localparam int unsigned PRESH    = 12;  // CORDIC prescale shift
  localparam int unsigned CW       = AXW + RW + PRESH + 3;  // CORDIC datapath
  localparam int unsigned ZW       = 28;  // angle, 2^-16 degree units
  localparam int unsigned AW       = ZW + 1;
  localparam int unsigned CAL_GROUP = 4;
  localparam int unsigned CAL_SHIFT = 2;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic signed [ZW-1:0] DEG_HALF = 28'sd11796480;
  localparam logic signed [ZW-1:0] DEG_FULL = 28'sd23592960;

  localparam logic [1:0] CFG_SENSOR_MODE   = 2'd0;
  localparam logic [1:0] CFG_AVERAGE_COUNT = 2'd1;

  typedef enum logic [1:0] {
    FN_CAL_START, FN_CAL_SAMPLE, FN_CAL_STOP, FN_HEADING
  } func_e;

  typedef enum logic [1:0] {
    MODE_SUM, MODE_A, MODE_B, MODE_AVG
  } mode_e;

  typedef enum logic [3:0] {
    BK_IDLE, BK_DIV, BK_CAL_OUT, BK_MUL, BK_PRE, BK_ROT, BK_ACC, BK_FIN
  } bk_state_e;

  // request passed from front to back
  typedef struct packed {
    logic                      cal;
    logic                      two;
    logic [1:0]                rsel0;
    logic signed [AXW-1:0]     x0;
    logic signed [AXW-1:0]     y0;
    logic signed [AXW-1:0]     x1;
    logic signed [AXW-1:0]     y1;
    logic [3:0][SW-1:0]        off;
    logic [2:0][SPW-1:0]       num;
    logic [2:0][SPW-1:0]       den;
  } job_t;

  typedef struct packed {
    logic                kind;
    logic [8:0]          heading;
    logic [3:0][SW-1:0]  off;
    logic [2:0][RW-1:0]  ratio;
  } res_t;

  // arctangent of 2^-i in 2^-16 degree units, rounded
  function automatic logic signed [ZW-1:0] ang_tab(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:  a = 28'sd2949120;
      5'd1:  a = 28'sd1740967;
      5'd2:  a = 28'sd919879;
      5'd3:  a = 28'sd466945;
      5'd4:  a = 28'sd234379;
      5'd5:  a = 28'sd117304;
      5'd6:  a = 28'sd58666;
      5'd7:  a = 28'sd29335;
      5'd8:  a = 28'sd14668;
      5'd9:  a = 28'sd7334;
      5'd10: a = 28'sd3667;
      5'd11: a = 28'sd1833;
      5'd12: a = 28'sd917;
      5'd13: a = 28'sd458;
      5'd14: a = 28'sd229;
      5'd15: a = 28'sd115;
      5'd16: a = 28'sd57;
      5'd17: a = 28'sd29;
      5'd18: a = 28'sd14;
      5'd19: a = 28'sd7;
      5'd20: a = 28'sd4;
      5'd21: a = 28'sd2;
      5'd22: a = 28'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/magnetometer_calibrate_and_heading_unit.sv =====
// Start and sample requests are handled in the front end; a stop request gives its
//   result once the shared 1-bit/cycle divider has formed all three span ratios.
// A heading runs the CORDIC once, twice in averaged mode.
// One request per cycle unless the 2-entry queue is full; back end runs one at a time.
// Reset (rst_ni low, async): extremes +-20000, sums clear, ratios 1.0, mode B, count 1.
// ----------------------------------------------------------------------------
// magnetometer_calibrate_and_heading_unit
// Two-magnetometer hard-iron calibration and CORDIC compass heading.
// ----------------------------------------------------------------------------
module magnetometer_calibrate_and_heading_unit #(
  parameter int unsigned CORDIC_STEPS    = 16,
  parameter int unsigned RATIO_FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] x_a_i,
  input  logic signed [15:0] y_a_i,
  input  logic signed [15:0] x_b_i,
  input  logic signed [15:0] y_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic [8:0]         heading_deg_o,
  output logic signed [15:0] offset_x_a_o,
  output logic signed [15:0] offset_y_a_o,
  output logic signed [15:0] offset_x_b_o,
  output logic signed [15:0] offset_y_b_o,
  output logic [15:0]        ratio_both_o,
  output logic [15:0]        ratio_a_o,
  output logic [15:0]        ratio_b_o
);
  import mchu_pkg::*;

  logic [1:0] mode_q;
  logic [7:0] avg_q;
  logic       push, pop, full, empty;
  job_t       job_w, job_r;
  res_t       res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_B;
      avg_q  <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SENSOR_MODE:   mode_q <= cfg_data_i[1:0];
        CFG_AVERAGE_COUNT: avg_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mchu_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i,
    .x_a_i, .y_a_i, .x_b_i, .y_b_i,
    .mode_i (mode_q), .avg_i (avg_q), .full_i (full),
    .push_o (push), .job_o (job_w)
  );

  mchu_fifo u_fifo (
    .clk_i, .rst_ni, .push_i (push), .din_i (job_w), .pop_i (pop),
    .dout_o (job_r), .full_o (full), .empty_o (empty)
  );

  mchu_back #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_back (
    .clk_i, .rst_ni, .job_i (job_r), .empty_i (empty), .pop_o (pop),
    .out_valid_o, .out_ready_i, .res_o (res)
  );

  assign result_kind_o = res.kind;
  assign heading_deg_o = res.heading;
  assign offset_x_a_o  = res.off[0];
  assign offset_y_a_o  = res.off[1];
  assign offset_x_b_o  = res.off[2];
  assign offset_y_b_o  = res.off[3];
  assign ratio_both_o  = res.ratio[0];
  assign ratio_a_o     = res.ratio[1];
  assign ratio_b_o     = res.ratio[2];

endmodule

// ===== sv/mchu_front.sv =====
// ----------------------------------------------------------------------------
// mchu_front
// Accepts samples, tracks calibration extremes and heading sums, and
// issues stop and heading requests to the back end.
// ----------------------------------------------------------------------------
module mchu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic signed [15:0]  x_a_i,
  input  logic signed [15:0]  y_a_i,
  input  logic signed [15:0]  x_b_i,
  input  logic signed [15:0]  y_b_i,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          avg_i,
  input  logic                full_i,
  output logic                push_o,
  output mchu_pkg::job_t      job_o
);
  import mchu_pkg::*;

  logic signed [SW-1:0]  amax_q [4];
  logic signed [SW-1:0]  amin_q [4];
  logic signed [CSW-1:0] gsum_q [4];
  logic [1:0]            gcnt_q;
  logic signed [HSW-1:0] hsum_q [4];
  logic [7:0]            hcnt_q;

  logic                  acc;
  func_e                 fn;
  logic signed [SW-1:0]  smp    [4];
  logic signed [CSW-1:0] gsum_n [4];
  logic signed [SW-1:0]  avg    [4];
  logic signed [HSW-1:0] hsum_n [4];
  logic signed [AXW-1:0] hx     [4];
  logic signed [SW:0]    diff   [4];
  logic [SW-1:0]         span   [4];
  logic signed [SW:0]    osum   [4];
  logic signed [SW:0]    ohalf  [4];
  logic [7:0]            need;
  logic [8:0]            hcnt_n;
  logic                  fire;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign fn         = func_e'(func_i);

  // per-axis arithmetic
  always_comb begin
    smp[0] = x_a_i;
    smp[1] = y_a_i;
    smp[2] = x_b_i;
    smp[3] = y_b_i;
    for (int k = 0; k < 4; k++) begin
      gsum_n[k] = gsum_q[k] + CSW'(smp[k]);
      avg[k]    = SW'(gsum_n[k] >>> CAL_SHIFT);
      hsum_n[k] = hsum_q[k] + HSW'(smp[k]);
      hx[k]     = AXW'(hsum_n[k]);
      diff[k]   = (SW+1)'(amax_q[k]) - (SW+1)'(amin_q[k]);
      span[k]   = diff[k][SW] ? SW'(-diff[k]) : SW'(diff[k]);
      osum[k]   = (SW+1)'(amax_q[k]) + (SW+1)'(amin_q[k]);
      // halve, truncating toward zero
      ohalf[k]  = (osum[k] + (SW+1)'(osum[k][SW])) >>> 1;
    end
  end

  // heading count
  assign need   = (avg_i == 8'd0) ? 8'd1 : avg_i;
  assign hcnt_n = {1'b0, hcnt_q} + 9'd1;
  assign fire   = hcnt_n >= {1'b0, need};

  // request build
  always_comb begin
    job_o = '0;
    if (fn == FN_CAL_STOP) begin
      job_o.cal    = 1'b1;
      job_o.num[0] = SPW'(span[0]) + SPW'(span[2]);
      job_o.den[0] = SPW'(span[1]) + SPW'(span[3]);
      job_o.num[1] = SPW'(span[0]);
      job_o.den[1] = SPW'(span[1]);
      job_o.num[2] = SPW'(span[2]);
      job_o.den[2] = SPW'(span[3]);
      job_o.off[0] = osum[0][SW-1:0];
      job_o.off[1] = osum[1][SW-1:0];
      job_o.off[2] = ohalf[2][SW-1:0];
      job_o.off[3] = ohalf[3][SW-1:0];
    end else begin
      unique case (mode_e'(mode_i))
        MODE_SUM: begin
          job_o.x0    = hx[2] - hx[0];
          job_o.y0    = hx[1] + hx[3];
          job_o.rsel0 = 2'd0;
        end
        MODE_A: begin
          job_o.x0    = -hx[0];
          job_o.y0    = hx[1];
          job_o.rsel0 = 2'd1;
        end
        MODE_B: begin
          job_o.x0    = hx[2];
          job_o.y0    = hx[3];
          job_o.rsel0 = 2'd2;
        end
        MODE_AVG: begin
          job_o.x0    = -hx[0];
          job_o.y0    = hx[1];
          job_o.rsel0 = 2'd1;
          job_o.x1    = hx[2];
          job_o.y1    = hx[3];
          job_o.two   = 1'b1;
        end
        default: job_o.rsel0 = 2'd0;
      endcase
    end
  end

  assign push_o = acc && ((fn == FN_CAL_STOP) || ((fn == FN_HEADING) && fire));

  // calibration and heading state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        amax_q[k] <= -16'sd20000;
        amin_q[k] <= 16'sd20000;
        gsum_q[k] <= '0;
        hsum_q[k] <= '0;
      end
      gcnt_q <= '0;
      hcnt_q <= '0;
    end else if (acc) begin
      unique case (fn)
        FN_CAL_START: begin
          for (int k = 0; k < 4; k++) begin
            amax_q[k] <= -16'sd20000;
            amin_q[k] <= 16'sd20000;
            gsum_q[k] <= '0;
          end
          gcnt_q <= '0;
        end
        FN_CAL_SAMPLE: begin
          if (gcnt_q == 2'(CAL_GROUP - 1)) begin
            for (int k = 0; k < 4; k++) begin
              if (amax_q[k] < avg[k]) amax_q[k] <= avg[k];
              if (amin_q[k] > avg[k]) amin_q[k] <= avg[k];
              gsum_q[k] <= '0;
            end
            gcnt_q <= '0;
          end else begin
            for (int k = 0; k < 4; k++) gsum_q[k] <= gsum_n[k];
            gcnt_q <= gcnt_q + 2'd1;
          end
        end
        FN_CAL_STOP: begin
        end
        FN_HEADING: begin
          if (fire) begin
            for (int k = 0; k < 4; k++) hsum_q[k] <= '0;
            hcnt_q <= '0;
          end else begin
            for (int k = 0; k < 4; k++) hsum_q[k] <= hsum_n[k];
            hcnt_q <= hcnt_n[7:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/mchu_fifo.sv =====
// ----------------------------------------------------------------------------
// mchu_fifo
// Short request queue between front and back end.
// ----------------------------------------------------------------------------
`include "magnetometer_calibrate_and_heading_unit_defines.svh"

module mchu_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mchu_pkg::job_t  din_i,
  input  logic            pop_i,
  output mchu_pkg::job_t  dout_o,
  output logic            full_o,
  output logic            empty_o
);
  import mchu_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  job_t          mem_q [FIFO_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= din_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + PW'(1);
      if (pop_i)  rp_q <= rp_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (PW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (PW+1)'(1);
    end
  end

  `MCHU_A_IMPL(a_fifo_bound, 1'b1, cnt_q <= (PW+1)'(FIFO_DEPTH), "fifo count over depth")
  `MCHU_A_IMPL(a_fifo_no_underflow, pop_i, !empty_o, "pop from empty fifo")
  `MCHU_A_IMPL(a_fifo_no_overflow, push_i && !pop_i, !full_o, "push into full fifo")

endmodule

// ===== sv/mchu_back.sv =====
// ----------------------------------------------------------------------------
// mchu_back
// Executes requests: shared restoring divider for span ratios and an
// iterative CORDIC for the heading angle, with a result register.
// ----------------------------------------------------------------------------
`include "magnetometer_calibrate_and_heading_unit_defines.svh"

module mchu_back #(
  parameter int unsigned CORDIC_STEPS    = 16,
  parameter int unsigned RATIO_FRAC_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mchu_pkg::job_t  job_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mchu_pkg::res_t  res_o
);
  import mchu_pkg::*;

  localparam int unsigned NW = SPW + RATIO_FRAC_BITS;   // dividend bits
  localparam int unsigned DW = $clog2(NW);
  localparam int unsigned IW = $clog2(CORDIC_STEPS);
  localparam int unsigned PW = AXW + RW + 1;             // Y times ratio

  bk_state_e            st_q, st_d;
  job_t                 job_q;
  logic [RW-1:0]        ratio_q [3];
  logic [1:0]           rk_q;
  logic [DW-1:0]        dc_q;
  logic [NW-1:0]        dvd_q;
  logic [SPW-1:0]       rem_q;
  logic                 sel_q;
  logic signed [AXW-1:0] xa_q;
  logic signed [PW-1:0] yp_q;
  logic signed [CW-1:0] x_q, v_q;
  logic signed [ZW-1:0] z_q;
  logic [IW-1:0]        i_q;
  logic signed [AW-1:0] acc_q;
  res_t                 out_q;
  logic                 ov_q;

  logic                 free;
  logic [SPW:0]         shf;
  logic                 ge;
  logic [NW-1:0]        dvd_n;
  logic [SPW-1:0]       rem_n;
  logic [RW-1:0]        rnew;
  logic [1:0]           rsel;
  logic [1:0]           rk_nx;
  logic signed [CW-1:0] xw, vw, dx, dv;
  logic signed [ZW-1:0] tab;
  logic signed [AW-1:0] theta;
  logic signed [AW:0]   hh;
  res_t                 cal_res, hd_res;

  assign free        = !ov_q || out_ready_i;
  assign pop_o       = (st_q == BK_IDLE) && !empty_i;
  assign out_valid_o = ov_q;
  assign res_o       = out_q;

  // next ratio slot, held at the last one
  assign rk_nx = (rk_q == 2'd2) ? 2'd2 : rk_q + 2'd1;

  // divider step
  always_comb begin
    shf   = {rem_q, dvd_q[NW-1]};
    ge    = shf >= {1'b0, job_q.den[rk_q]};
    rem_n = ge ? SPW'(shf - {1'b0, job_q.den[rk_q]}) : shf[SPW-1:0];
    dvd_n = {dvd_q[NW-2:0], ge};
    if (job_q.den[rk_q] == '0)         rnew = '1;
    else if (dvd_n > NW'({RW{1'b1}})) rnew = '1;
    else                               rnew = dvd_n[RW-1:0];
  end

  // CORDIC setup and step
  always_comb begin
    rsel = sel_q ? 2'd2 : job_q.rsel0;
    xw   = CW'(xa_q) <<< (RATIO_FRAC_BITS + PRESH);
    vw   = -(CW'(yp_q) <<< PRESH);
    dx   = v_q >>> i_q;
    dv   = x_q >>> i_q;
    tab  = ang_tab(5'(i_q));
  end

  // heading wrap
  always_comb begin
    theta = job_q.two ? (acc_q >>> 1) : acc_q;
    hh    = (AW+1)'(theta) + (AW+1)'(DEG_HALF);
    if (hh < 0) hh = hh + (AW+1)'(DEG_FULL);
    if (hh > (AW+1)'(DEG_FULL)) hh = hh - (AW+1)'(DEG_FULL);
    if (hh < 0) hh = '0;
    hd_res         = '0;
    hd_res.heading = hh[24:16];
    cal_res        = '0;
    cal_res.kind   = 1'b1;
    cal_res.off    = job_q.off;
    for (int k = 0; k < 3; k++) cal_res.ratio[k] = ratio_q[k];
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE:    if (!empty_i) st_d = job_i.cal ? BK_DIV : BK_MUL;
      BK_DIV:     if (dc_q == '0 && rk_q == 2'd2) st_d = BK_CAL_OUT;
      BK_CAL_OUT: if (free) st_d = BK_IDLE;
      BK_MUL:     st_d = BK_PRE;
      BK_PRE:     st_d = (yp_q == '0) ? BK_ACC : BK_ROT;
      BK_ROT:     if (i_q == IW'(CORDIC_STEPS - 1)) st_d = BK_ACC;
      BK_ACC:     st_d = (job_q.two && !sel_q) ? BK_MUL : BK_FIN;
      BK_FIN:     if (free) st_d = BK_IDLE;
      default:    st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BK_IDLE;
    else         st_q <= st_d;
  end

  // span ratios and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) ratio_q[k] <= RW'(1 << RATIO_FRAC_BITS);
      ov_q <= 1'b0;
    end else begin
      if (st_q == BK_DIV && dc_q == '0) ratio_q[rk_q] <= rnew;
      if (((st_q == BK_CAL_OUT) || (st_q == BK_FIN)) && free) ov_q <= 1'b1;
      else if (out_ready_i)                                   ov_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      BK_IDLE: begin
        job_q <= job_i;
        rk_q  <= '0;
        dc_q  <= DW'(NW - 1);
        dvd_q <= {job_i.num[0], {RATIO_FRAC_BITS{1'b0}}};
        rem_q <= '0;
        sel_q <= 1'b0;
        acc_q <= '0;
      end
      BK_DIV: begin
        if (dc_q == '0) begin
          rk_q  <= rk_q + 2'd1;
          dc_q  <= DW'(NW - 1);
          dvd_q <= {job_q.num[rk_nx], {RATIO_FRAC_BITS{1'b0}}};
          rem_q <= '0;
        end else begin
          dc_q  <= dc_q - DW'(1);
          dvd_q <= dvd_n;
          rem_q <= rem_n;
        end
      end
      BK_CAL_OUT: if (free) out_q <= cal_res;
      BK_MUL: begin
        xa_q <= sel_q ? job_q.x1 : job_q.x0;
        yp_q <= (sel_q ? job_q.y1 : job_q.y0) * $signed({1'b0, ratio_q[rsel]});
      end
      BK_PRE: begin
        i_q <= '0;
        if (yp_q == '0) begin
          z_q <= (xa_q < 0) ? -DEG_HALF : '0;
        end else if (xw < 0) begin
          z_q <= (vw > 0) ? DEG_HALF : -DEG_HALF;
          x_q <= -xw;
          v_q <= -vw;
        end else begin
          z_q <= '0;
          x_q <= xw;
          v_q <= vw;
        end
      end
      BK_ROT: begin
        i_q <= i_q + IW'(1);
        if (v_q > 0) begin
          x_q <= x_q + dx;
          v_q <= v_q - dv;
          z_q <= z_q + tab;
        end else begin
          x_q <= x_q - dx;
          v_q <= v_q + dv;
          z_q <= z_q - tab;
        end
      end
      BK_ACC: begin
        acc_q <= acc_q + AW'(z_q);
        sel_q <= 1'b1;
      end
      BK_FIN: if (free) out_q <= hd_res;
      default: begin
      end
    endcase
  end

  `MCHU_A_IMPL(a_cal_no_heading, ov_q && out_q.kind, out_q.heading == 9'd0,
               "calibration result with heading set")
  `MCHU_A_IMPL(a_heading_range, ov_q && !out_q.kind, out_q.heading <= 9'd360,
               "heading above 360")
  `MCHU_A_NEXT(a_pop_starts, pop_o, st_q != BK_IDLE, "popped request not started")

endmodule
